>>> rtl/ptf_pkg.sv
// Shared constants, codes and types for the page table with free frame list.
package ptf_pkg;

	localparam int PROC_W      = 4;
	localparam int PAGE_W      = 4;
	localparam int OFFSET_BITS = 12;
	localparam int VA_W        = 16;
	localparam int FRAME_W     = 5;
	localparam int FREED_W     = 5;
	localparam int STAT_W      = 2;

	localparam int PROCESSES   = 1 << PROC_W;
	localparam int PAGES       = 1 << PAGE_W;
	localparam int FRAMES      = 1 << FRAME_W;
	localparam int ENTRY_W     = PROC_W + PAGE_W;
	localparam int ENTRIES     = PROCESSES * PAGES;
	localparam int RING_PTR_W  = FRAME_W + 1;

	localparam int IN_DATA_W   = 24;
	localparam int OUT_DATA_W  = 24;

	typedef enum logic {
		FN_XLATE   = 1'b0,
		FN_RELEASE = 1'b1
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_HIT = 2'd0,
		ST_NEW = 2'd1,
		ST_OOF = 2'd2,
		ST_REL = 2'd3
	} status_t;

	typedef struct packed {
		logic               push;
		logic               pop;
		logic [FRAME_W-1:0] push_frame;
	} ring_ctl_t;

	typedef struct packed {
		logic               empty;
		logic               full;
		logic [FRAME_W-1:0] head_frame;
	} ring_stat_t;

endpackage

>>> rtl/page_table_with_free_frame_list.sv
// Top level: per-process page tables with a free frame ring, run by a small sequencer.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+------------------------------------------------
//  s_*     | in  | s_tvalid/s_tready | tuser: func; tdata: process, virtual_address
//  m_*     | out | m_tvalid/m_tready | tuser: status; tdata: frame, page_offset, freed
//
// A translate beat runs through table RAM read, decide/update and output load.
// A release beat walks every page of the process, reading one table entry per cycle
// through the single RAM read port and pushing at most one frame per cycle.
// s_tready is high only while the sequencer is idle; a stalled output beat holds
// the sequencer until it can be loaded. Reset clears all valid bits and refills
// the ring at once; no clearing pass is needed.
module page_table_with_free_frame_list (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [ptf_pkg::IN_DATA_W-1:0]  s_tdata,  // [3:0] process, [19:4] virtual_address
	input  logic                           s_tuser,  // [0] func
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [ptf_pkg::OUT_DATA_W-1:0] m_tdata,  // [4:0] frame, [16:5] page_offset,
	                                                 // [21:17] freed_count
	output logic [ptf_pkg::STAT_W-1:0]     m_tuser   // [1:0] status
);
	import ptf_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_XLATE,
		S_WALK,
		S_OUT
	} state_t;

	state_t                 state_q;
	logic [PROC_W-1:0]      proc_q;
	logic [PAGE_W-1:0]      page_q;
	logic [OFFSET_BITS-1:0] offs_q;
	logic [PAGE_W-1:0]      cnt_q;
	logic [FREED_W-1:0]     freed_q;
	logic [FRAME_W-1:0]     res_frame_q;
	status_t                res_status_q;
	logic [ENTRIES-1:0]     valid_q;

	logic                   m_tvalid_q;
	logic [OUT_DATA_W-1:0]  m_tdata_q;
	status_t                m_tuser_q;

	logic                   accept;
	logic [PROC_W-1:0]      in_proc;
	logic [VA_W-1:0]        in_va;
	logic [PAGE_W-1:0]      in_page;
	logic                   out_free;

	logic                   ram_re;
	logic                   ram_we;
	logic [ENTRY_W-1:0]     ram_raddr;
	logic [FRAME_W-1:0]     ram_rdata;
	logic [ENTRY_W-1:0]     cur_idx;
	logic                   cur_valid;
	logic                   miss_take;

	ring_ctl_t              ring_ctl;
	ring_stat_t             ring_stat;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign in_proc  = s_tdata[PROC_W-1:0];
	assign in_va    = s_tdata[PROC_W +: VA_W];
	assign in_page  = in_va[OFFSET_BITS +: PAGE_W];
	assign out_free = !m_tvalid_q || m_tready;

	// Entry under work: the latched page on translate, the walk counter on release.
	assign cur_idx   = {proc_q, (state_q == S_WALK) ? cnt_q : page_q};
	assign cur_valid = valid_q[cur_idx];
	assign miss_take = (state_q == S_XLATE) && !cur_valid && !ring_stat.empty;

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = cur_idx;
		if (accept) begin
			ram_re    = 1'b1;
			ram_raddr = {in_proc, (s_tuser == FN_RELEASE) ? PAGE_W'(0) : in_page};
		end else if (state_q == S_WALK) begin
			// Prefetch the next page while the current one is retired.
			ram_re    = 1'b1;
			ram_raddr = {proc_q, cnt_q + PAGE_W'(1)};
		end
	end

	assign ram_we = miss_take;

	assign ring_ctl.pop        = miss_take;
	assign ring_ctl.push       = (state_q == S_WALK) && cur_valid && !ring_stat.full;
	assign ring_ctl.push_frame = ram_rdata;

	ptf_ram #(
		.WIDTH(FRAME_W),
		.DEPTH(ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cur_idx),
		.wdata(ring_stat.head_frame),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	ptf_ring u_ring (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ring_ctl),
		.stat  (ring_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			m_tvalid_q   <= 1'b0;
			proc_q       <= '0;
			page_q       <= '0;
			offs_q       <= '0;
			cnt_q        <= '0;
			freed_q      <= '0;
			res_frame_q  <= '0;
			res_status_q <= ST_HIT;
			m_tdata_q    <= '0;
			m_tuser_q    <= ST_HIT;
		end else begin
			// Load a finished result, or drop the beat the receiver took.
			if (state_q == S_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= OUT_DATA_W'({freed_q, offs_q, res_frame_q});
				m_tuser_q  <= res_status_q;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						proc_q  <= in_proc;
						page_q  <= in_page;
						cnt_q   <= '0;
						freed_q <= '0;
						if (s_tuser == FN_RELEASE) begin
							offs_q  <= '0;
							state_q <= S_WALK;
						end else begin
							offs_q  <= in_va[OFFSET_BITS-1:0];
							state_q <= S_XLATE;
						end
					end
				end
				S_XLATE: begin
					if (cur_valid) begin
						res_frame_q  <= ram_rdata;
						res_status_q <= ST_HIT;
					end else if (miss_take) begin
						valid_q[cur_idx] <= 1'b1;
						res_frame_q      <= ring_stat.head_frame;
						res_status_q     <= ST_NEW;
					end else begin
						res_frame_q  <= '0;
						res_status_q <= ST_OOF;
					end
					state_q <= S_OUT;
				end
				S_WALK: begin
					if (cur_valid) begin
						valid_q[cur_idx] <= 1'b0;
					end
					if (ring_ctl.push) begin
						freed_q <= freed_q + FREED_W'(1);
					end
					cnt_q <= cnt_q + PAGE_W'(1);
					if (cnt_q == PAGE_W'(PAGES - 1)) begin
						res_frame_q  <= '0;
						res_status_q <= ST_REL;
						state_q      <= S_OUT;
					end
				end
				S_OUT: begin
					// Hold the result until the output register is free.
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

>>> rtl/ptf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ptf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/ptf_ring.sv
// FIFO ring of free frame numbers with wrap-bit head and tail pointers.
module ptf_ring (
	input  logic                clk,
	input  logic                arst_n,
	input  ptf_pkg::ring_ctl_t  ctl,
	output ptf_pkg::ring_stat_t stat
);
	import ptf_pkg::*;

	logic [FRAME_W-1:0]    slot_q [FRAMES];
	logic [RING_PTR_W-1:0] head_q;
	logic [RING_PTR_W-1:0] tail_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < FRAMES; k++) begin
				slot_q[k] <= FRAME_W'(k);
			end
			head_q <= '0;
			tail_q <= RING_PTR_W'(FRAMES);
		end else begin
			if (ctl.push) begin
				slot_q[tail_q[FRAME_W-1:0]] <= ctl.push_frame;
				tail_q <= tail_q + RING_PTR_W'(1);
			end
			if (ctl.pop) begin
				head_q <= head_q + RING_PTR_W'(1);
			end
		end
	end

	// Pointers count modulo twice the depth; the top bit tells full from empty.
	assign stat.empty      = (head_q == tail_q);
	assign stat.full       = (head_q[RING_PTR_W-1] != tail_q[RING_PTR_W-1]) &&
	                         (head_q[FRAME_W-1:0] == tail_q[FRAME_W-1:0]);
	assign stat.head_frame = slot_q[head_q[FRAME_W-1:0]];

endmodule

>>> rtl/ptf_checker.sv
// Port-level checker for the page table block, bound to the top level.
module ptf_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [ptf_pkg::IN_DATA_W-1:0]  s_tdata,
	input logic                           s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [ptf_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [ptf_pkg::STAT_W-1:0]     m_tuser
);
	import ptf_pkg::*;

	// The sequencer is busy in the cycle after it takes a beat.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input ready right after an accepted beat");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled output beat changed");

	// Release carries only a count; frame and offset stay zero.
	a_release_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_REL) |-> (m_tdata[16:0] == 17'd0))
		else $error("release beat carries frame or offset");

	// Only a release may report freed frames; out of frames reports no frame.
	a_translate_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_REL) |->
		(m_tdata[21:17] == 5'd0 && (m_tuser != ST_OOF || m_tdata[4:0] == 5'd0)))
		else $error("translate beat has bad count or frame");

endmodule

bind page_table_with_free_frame_list ptf_checker u_ptf_checker (.*);

>>> bench/tb_page_table_with_free_frame_list.sv
// Self-checking testbench for the page table with free frame ring.
module tb_page_table_with_free_frame_list;
	timeunit 1ns;
	timeprecision 1ps;

	import ptf_pkg::*;

	localparam int STALL_LIMIT  = 2000;  // quiet cycles before the run is declared hung
	localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
	localparam int DRAIN_CYCLES = 2 * PAGES + 8;
	localparam int PHASE_ITEMS  = 500;

	typedef struct {
		logic [FRAME_W-1:0]     frame;
		logic [OFFSET_BITS-1:0] offset;
		status_t                status;
		logic [FREED_W-1:0]     freed;
	} xlate_result_t;

	// Tracks table mappings and the free ring; predicts one response per request.
	class frame_alloc_tracker;
		bit                  mapped[ENTRIES];
		logic [FRAME_W-1:0]  frame_of[ENTRIES];
		logic [FRAME_W-1:0]  free_list[FRAMES];
		logic [RING_PTR_W-1:0] head;
		logic [RING_PTR_W-1:0] tail;
		xlate_result_t       pending_results[$];
		int                  errors;

		function new();
			for (int k = 0; k < ENTRIES; k++) begin
				mapped[k] = 1'b0;
				frame_of[k] = '0;
			end
			for (int k = 0; k < FRAMES; k++)
				free_list[k] = FRAME_W'(k);
			head = '0;
			tail = RING_PTR_W'(FRAMES);
			errors = 0;
		endfunction

		function void accept_request(func_t fn, logic [PROC_W-1:0] proc,
				logic [VA_W-1:0] va);
			xlate_result_t r;
			int base;
			int e;
			logic [RING_PTR_W-1:0] used;
			r.frame = '0;
			r.offset = '0;
			r.status = ST_REL;
			r.freed = '0;
			base = proc * PAGES;
			if (fn == FN_RELEASE) begin
				for (int p = 0; p < PAGES; p++) begin
					e = base + p;
					if (mapped[e]) begin
						used = tail - head;
						// a full ring drops the frame but still clears the entry
						if (used < FRAMES) begin
							free_list[tail[FRAME_W-1:0]] = frame_of[e];
							tail++;
							r.freed++;
						end
						mapped[e] = 1'b0;
						frame_of[e] = '0;
					end
				end
			end else begin
				e = base + va[VA_W-1:OFFSET_BITS];
				r.offset = va[OFFSET_BITS-1:0];
				if (mapped[e]) begin
					r.frame = frame_of[e];
					r.status = ST_HIT;
				end else if (head != tail) begin
					frame_of[e] = free_list[head[FRAME_W-1:0]];
					mapped[e] = 1'b1;
					head++;
					r.frame = frame_of[e];
					r.status = ST_NEW;
				end else begin
					r.status = ST_OOF;
				end
			end
			pending_results.push_back(r);
		endfunction

		function void check_field(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				errors++;
			end
		endfunction

		function void match_response(logic [OUT_DATA_W-1:0] data, logic [STAT_W-1:0] user);
			xlate_result_t r;
			if (pending_results.size() == 0) begin
				$error("unexpected response: tdata %h tuser %h", data, user);
				errors++;
				return;
			end
			r = pending_results.pop_front();
			check_field("frame", r.frame, data[4:0]);
			check_field("page_offset", r.offset, data[16:5]);
			check_field("freed_count", r.freed, data[21:17]);
			check_field("tdata_pad", 0, data[OUT_DATA_W-1:22]);
			check_field("status", r.status, user);
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b1;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STAT_W-1:0]     m_tuser;

	int                    tx_idle_pct = 0;
	int                    rx_stall_pct = 0;
	bit                    hold_req = 1'b0;
	frame_alloc_tracker    tracker = new();

	page_table_with_free_frame_list DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Call on a rising-edge step; leaves tvalid high so back-to-back beats need no toggle.
	task automatic send_request(input func_t fn, input logic [PROC_W-1:0] proc,
			input logic [VA_W-1:0] va);
		if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser <= fn;
		s_tdata <= {{(IN_DATA_W - VA_W - PROC_W){1'b0}}, va, proc};
		do @(posedge clk); while (!s_tready);
		tracker.accept_request(fn, proc, va);
	endtask

	task automatic send_random(input int count, input int hold_at);
		func_t fn;
		logic [PROC_W-1:0] proc;
		logic [VA_W-1:0] va;
		for (int i = 0; i < count; i++) begin
			if (i == hold_at)
				hold_req <= 1'b1;
			fn = ($urandom_range(7) == 0) ? FN_RELEASE : FN_XLATE;
			// favor a few processes and pages so hits and reuse are common
			proc = $urandom_range(1) ? PROC_W'($urandom_range(3)) : PROC_W'($urandom);
			va = VA_W'($urandom);
			if ($urandom_range(1))
				va[VA_W-1:OFFSET_BITS] = PAGE_W'($urandom_range(3));
			send_request(fn, proc, va);
		end
	endtask

	// Receiver: check each accepted beat, then pick tready for the next edge.
	initial begin : receiver
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				tracker.match_response(m_tdata, m_tuser);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !(rx_stall_pct > 0 && $urandom_range(99) < rx_stall_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b0);
		wait (arst_n === 1'b1);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// release with nothing mapped, first map, hit, address extremes
		send_request(FN_RELEASE, 4'd0, 16'h0000);
		send_request(FN_XLATE, 4'd0, 16'h0000);
		send_request(FN_XLATE, 4'd0, 16'h0FFF);
		send_request(FN_XLATE, 4'd15, 16'hFFFF);
		send_request(FN_XLATE, 4'd15, 16'hF000);
		send_request(FN_XLATE, 4'd5, 16'hA5A5);
		send_request(FN_XLATE, 4'd10, 16'h5A5A);
		send_request(FN_XLATE, 4'd10, 16'h5000);
		send_request(FN_XLATE, 4'd10, 16'h6FFF);
		// release ignores the address; freed frames go to the ring tail
		send_request(FN_RELEASE, 4'd15, 16'hFFFF);
		send_request(FN_XLATE, 4'd3, 16'h1234);
		send_request(FN_RELEASE, 4'd10, 16'h0000);
		send_request(FN_RELEASE, 4'd10, 16'hFFFF);
		send_request(FN_XLATE, 4'd15, 16'hFFFF);
		send_request(FN_XLATE, 4'd0, 16'h0001);
		send_request(FN_RELEASE, 4'd0, 16'h8000);
		send_request(FN_XLATE, 4'd0, 16'h0000);
		send_request(FN_XLATE, 4'd7, 16'h7777);
		send_request(FN_RELEASE, 4'd7, 16'h0000);
		send_request(FN_RELEASE, 4'd15, 16'h0000);

		// no idling; a long receiver hold partway through backs up the input
		send_random(PHASE_ITEMS, 100);
		tx_idle_pct = 86;
		send_random(PHASE_ITEMS, -1);
		tx_idle_pct = 0;
		rx_stall_pct <= 86;
		send_random(PHASE_ITEMS, -1);
		tx_idle_pct = 15;
		rx_stall_pct <= 15;
		send_random(PHASE_ITEMS, -1);

		s_tvalid <= 1'b0;
		rx_stall_pct <= 0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
